/* rtl/pbrb_pkg.sv */
// Shared types and constants of the packetizing byte ring buffer.
package pbrb_pkg;

    localparam int QUEUE_SLOTS_DEF = 16;
    localparam int MAX_PACKET_DEF  = 64;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 7;
    localparam int COUNT_W         = 32;
    localparam int SLOT_MAX_W      = 8;
    localparam int PKT_SIZE_RESET  = 64;
    localparam int CMDQ_DEPTH      = 2;
    localparam int OUT_DEPTH       = 4;

    typedef enum logic [1:0] {
        REQ_APPEND   = 2'd0,
        REQ_READ     = 2'd1,
        REQ_MARK_END = 2'd2,
        REQ_RESTART  = 2'd3
    } t_req_type;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

    // One read transaction as the front hands it to the back.
    typedef struct packed {
        logic [SLOT_MAX_W-1:0] slot;
        logic [LEN_W-1:0]      count;
        logic [LEN_W-1:0]      len;
        logic [COUNT_W-1:0]    read_count;
        logic                  done;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               last_of_run;
        logic [LEN_W-1:0]   reported_length;
        logic [COUNT_W-1:0] read_count;
        logic               stream_done;
    } t_result;

endpackage

/* rtl/pbrb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pbrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pbrb_front.sv */
// Front part: input holding stage, ring pointers, store writes and read classification.
module pbrb_front #(
    parameter int QUEUE_SLOTS = pbrb_pkg::QUEUE_SLOTS_DEF,
    parameter int MAX_PACKET  = pbrb_pkg::MAX_PACKET_DEF,
    parameter int ADDR_W      = $clog2(QUEUE_SLOTS * MAX_PACKET)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [1:0]                   i_req_type,
    input  logic [pbrb_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                         i_end_flag,
    input  logic [pbrb_pkg::LEN_W-1:0]   i_read_limit,
    input  logic                         i_cfg_we,
    input  logic [pbrb_pkg::LEN_W-1:0]   i_cfg_wdata,
    input  logic                         i_back_busy,
    input  logic                         i_cmdq_full,
    output logic                         o_cmd_push,
    output pbrb_pkg::t_cmd               o_cmd,
    output logic                         o_ram_we,
    output logic [ADDR_W-1:0]            o_ram_waddr,
    output logic [pbrb_pkg::BYTE_W-1:0]  o_ram_wdata
);

    localparam int SLOT_W = $clog2(QUEUE_SLOTS);
    localparam int LEN_W  = pbrb_pkg::LEN_W;
    localparam int CNT_W  = pbrb_pkg::COUNT_W;

    logic                        r_in_valid, n_in_valid;
    pbrb_pkg::t_req_type         r_req;
    logic [pbrb_pkg::BYTE_W-1:0] r_data;
    logic                        r_end;
    logic [LEN_W-1:0]            r_limit;

    logic [SLOT_W-1:0] r_ws, n_ws;
    logic [SLOT_W-1:0] r_rs, n_rs;
    logic [LEN_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]  r_pr, n_pr;
    logic              r_end_seen, n_end_seen;
    logic [LEN_W-1:0]  r_packet_size;

    logic [LEN_W-1:0]  eff_size;
    logic [SLOT_W-1:0] ws_next, rs_next;
    logic [LEN_W-1:0]  fill_inc;
    logic              advance, go, accept;

    always_comb begin
        if (r_packet_size == '0) begin
            eff_size = LEN_W'(1);
        end else if (r_packet_size > LEN_W'(MAX_PACKET)) begin
            eff_size = LEN_W'(MAX_PACKET);
        end else begin
            eff_size = r_packet_size;
        end
    end

    assign ws_next  = (r_ws == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : r_ws + 1'b1;
    assign rs_next  = (r_rs == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : r_rs + 1'b1;
    assign fill_inc = r_fill + 1'b1;

    // Appends wait while a read is queued or still fetching from the store; reads wait while the command queue is full.
    always_comb begin
        case (r_req)
            pbrb_pkg::REQ_READ:   advance = !i_cmdq_full;
            pbrb_pkg::REQ_APPEND: advance = !i_back_busy;
            default:              advance = 1'b1;
        endcase
    end

    assign go         = r_in_valid && advance;
    assign o_full     = r_in_valid && !advance;
    assign accept     = i_push && !o_full;
    assign n_in_valid = accept || (r_in_valid && !go);

    always_comb begin
        n_ws        = r_ws;
        n_rs        = r_rs;
        n_fill      = r_fill;
        n_pr        = r_pr;
        n_end_seen  = r_end_seen;
        o_ram_we    = 1'b0;
        o_ram_waddr = ADDR_W'(r_ws) * ADDR_W'(MAX_PACKET) + ADDR_W'(r_fill);
        o_ram_wdata = r_data;
        o_cmd_push  = 1'b0;
        o_cmd       = '0;
        if (go) begin
            case (r_req)
                pbrb_pkg::REQ_APPEND: begin
                    if (!r_end_seen) begin
                        n_end_seen = r_end;
                        if (r_rs != ws_next) begin
                            o_ram_we = 1'b1;
                            if (fill_inc >= eff_size) begin
                                n_ws   = ws_next;
                                n_fill = '0;
                            end else begin
                                n_fill = fill_inc;
                            end
                        end
                    end
                end
                pbrb_pkg::REQ_READ: begin
                    o_cmd_push       = 1'b1;
                    o_cmd.slot       = pbrb_pkg::SLOT_MAX_W'(r_rs);
                    o_cmd.read_count = r_pr;
                    o_cmd.done       = r_end_seen;
                    if (r_limit == '0) begin
                        o_cmd.count = '0;
                        o_cmd.len   = '0;
                    end else if (r_rs != r_ws) begin
                        o_cmd.count      = (r_limit < eff_size) ? r_limit : eff_size;
                        o_cmd.len        = eff_size;
                        o_cmd.read_count = r_pr + 1'b1;
                        n_rs             = rs_next;
                        n_pr             = r_pr + 1'b1;
                    end else if (r_end_seen) begin
                        // Flush of the partial packet at end of stream.
                        o_cmd.count      = (r_limit < r_fill) ? r_limit : r_fill;
                        o_cmd.len        = r_fill;
                        o_cmd.read_count = r_pr + 1'b1;
                        n_fill           = '0;
                        n_pr             = r_pr + 1'b1;
                    end else begin
                        o_cmd.count = '0;
                        o_cmd.len   = '0;
                    end
                end
                pbrb_pkg::REQ_MARK_END: begin
                    n_end_seen = 1'b1;
                end
                pbrb_pkg::REQ_RESTART: begin
                    n_ws       = '0;
                    n_rs       = '0;
                    n_fill     = '0;
                    n_pr       = '0;
                    n_end_seen = 1'b0;
                end
                default: begin
                    n_end_seen = r_end_seen;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_ws          <= '0;
            r_rs          <= '0;
            r_fill        <= '0;
            r_pr          <= '0;
            r_end_seen    <= 1'b0;
            r_packet_size <= LEN_W'(pbrb_pkg::PKT_SIZE_RESET);
        end else begin
            r_in_valid <= n_in_valid;
            r_ws       <= n_ws;
            r_rs       <= n_rs;
            r_fill     <= n_fill;
            r_pr       <= n_pr;
            r_end_seen <= n_end_seen;
            if (i_cfg_we) begin
                r_packet_size <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= pbrb_pkg::t_req_type'(i_req_type);
            r_data  <= i_data_byte;
            r_end   <= i_end_flag;
            r_limit <= i_read_limit;
        end
    end

endmodule

/* rtl/pbrb_cmd_queue.sv */
// Short queue of read transactions between the front and the back.
module pbrb_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pbrb_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output pbrb_pkg::t_cmd o_cmd,
    output logic           o_empty
);

    localparam int DEPTH = pbrb_pkg::CMDQ_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pbrb_pkg::t_cmd   r_q [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

/* rtl/pbrb_back.sv */
// Back part: streams each read transaction from the store into the result queue.
module pbrb_back #(
    parameter int QUEUE_SLOTS = pbrb_pkg::QUEUE_SLOTS_DEF,
    parameter int MAX_PACKET  = pbrb_pkg::MAX_PACKET_DEF,
    parameter int ADDR_W      = $clog2(QUEUE_SLOTS * MAX_PACKET)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_empty,
    input  pbrb_pkg::t_cmd              i_cmd,
    output logic                        o_cmd_pop,
    output logic                        o_ram_re,
    output logic [ADDR_W-1:0]           o_ram_raddr,
    input  logic [pbrb_pkg::BYTE_W-1:0] i_ram_rdata,
    input  logic                        i_pop,
    output logic                        o_empty,
    output pbrb_pkg::t_result           o_result,
    output logic                        o_busy
);

    localparam int SLOT_W = $clog2(QUEUE_SLOTS);
    localparam int LEN_W  = pbrb_pkg::LEN_W;
    localparam int DEPTH  = pbrb_pkg::OUT_DEPTH;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    pbrb_pkg::t_back_state r_state, n_state;
    pbrb_pkg::t_cmd        r_cur;
    logic [LEN_W-1:0]      r_idx;

    logic                  r_iss_valid;
    pbrb_pkg::t_result     r_iss;

    pbrb_pkg::t_result     r_q [DEPTH];
    logic [PTR_W-1:0]      r_wp, r_rp;
    logic [CNT_W-1:0]      r_cnt;

    logic                  space, issue, last_issue, do_pop;
    logic [LEN_W-1:0]      idx_inc;
    pbrb_pkg::t_result     push_entry;

    assign idx_inc    = r_idx + 1'b1;
    assign last_issue = (r_cur.count == '0) || (idx_inc >= r_cur.count);
    assign space      = (r_cnt + CNT_W'(r_iss_valid)) < CNT_W'(DEPTH);

    always_comb begin
        n_state = r_state;
        case (r_state)
            pbrb_pkg::BK_IDLE: if (!i_cmd_empty) n_state = pbrb_pkg::BK_RUN;
            pbrb_pkg::BK_RUN:  if (space && last_issue) n_state = pbrb_pkg::BK_IDLE;
            default:           n_state = pbrb_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        issue     = 1'b0;
        case (r_state)
            pbrb_pkg::BK_IDLE: o_cmd_pop = !i_cmd_empty;
            pbrb_pkg::BK_RUN:  issue     = space;
            default:           issue     = 1'b0;
        endcase
    end

    assign o_ram_re    = issue && (r_cur.count != '0);
    assign o_ram_raddr = ADDR_W'(r_cur.slot[SLOT_W-1:0]) * ADDR_W'(MAX_PACKET)
                         + ADDR_W'(r_idx);
    assign o_busy      = (r_state == pbrb_pkg::BK_RUN) || !i_cmd_empty;

    always_comb begin
        push_entry          = r_iss;
        push_entry.out_byte = r_iss.byte_valid ? i_ram_rdata : '0;
    end

    assign do_pop   = i_pop && (r_cnt != '0);
    assign o_empty  = (r_cnt == '0);
    assign o_result = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pbrb_pkg::BK_IDLE;
            r_iss_valid <= 1'b0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_iss_valid <= issue;
            if (r_iss_valid) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(r_iss_valid) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cur <= i_cmd;
            r_idx <= '0;
        end else if (issue) begin
            r_idx <= idx_inc;
        end
        if (issue) begin
            r_iss.out_byte        <= '0;
            r_iss.byte_valid      <= (r_cur.count != '0);
            r_iss.last_of_run     <= last_issue;
            r_iss.reported_length <= r_cur.len;
            r_iss.read_count      <= r_cur.read_count;
            r_iss.stream_done     <= r_cur.done;
        end
        if (r_iss_valid) begin
            r_q[r_wp] <= push_entry;
        end
    end

endmodule

/* rtl/packetizing_byte_ring_buffer_unit.sv */
// Top level of the packetizing byte ring buffer.
//
// The block gathers a byte stream into packets held in a ring of QUEUE_SLOTS
// slots of MAX_PACKET bytes each and hands whole packets back on request. Both
// sides look like a queue: a transaction enters when push is high and full is
// low, and a result leaves when pop is high and empty is low. An append, a
// mark-end or a restart transaction produces no result; a read transaction
// produces one result per delivered byte, or one result with byte_valid low
// when nothing is delivered, and its last result has last_of_run high. The
// packet size register is written through i_cfg_we and i_cfg_wdata; the user
// must write it only while the block is idle, and the block itself does not
// enforce this. Zero acts as one and values above MAX_PACKET act as MAX_PACKET.
// Mark-end and restart are taken at one transaction per cycle, appends too
// while no read is queued or fetching. A read is registered in the front's
// input stage and enters a two-entry command queue; the back sequencer then
// fetches one byte per cycle from the store while the result queue has room,
// the store's single read port with registered data setting that pace. Reads
// queue up behind one another; an append that arrives while a read is queued
// or still fetching waits until every queued read has issued its last fetch. The
// result fields read_count and stream_done carry the state as it stood
// right after the read that produced them. The store needs no clearing pass
// after reset.
module packetizing_byte_ring_buffer_unit #(
    parameter int QUEUE_SLOTS = pbrb_pkg::QUEUE_SLOTS_DEF,
    parameter int MAX_PACKET  = pbrb_pkg::MAX_PACKET_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   i_req_type,
    input  logic [pbrb_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                         i_end_flag,
    input  logic [pbrb_pkg::LEN_W-1:0]   i_read_limit,
    input  logic                         i_cfg_we,
    input  logic [pbrb_pkg::LEN_W-1:0]   i_cfg_wdata,
    output logic                         empty,
    input  logic                         pop,
    output logic [pbrb_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                         o_byte_valid,
    output logic                         o_last_of_run,
    output logic [pbrb_pkg::LEN_W-1:0]   o_reported_length,
    output logic [pbrb_pkg::COUNT_W-1:0] o_read_count,
    output logic                         o_stream_done
);

    // The store holds every slot back to back, MAX_PACKET bytes per slot.
    localparam int DEPTH  = QUEUE_SLOTS * MAX_PACKET;
    localparam int ADDR_W = $clog2(DEPTH);

    pbrb_pkg::t_cmd              front_cmd, queue_cmd;
    pbrb_pkg::t_result           result;
    logic                        cmd_push, cmdq_full, cmdq_empty, cmd_pop;
    logic                        back_busy;
    logic                        ram_we, ram_re;
    logic [ADDR_W-1:0]           ram_waddr, ram_raddr;
    logic [pbrb_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;

    // The front classifies each transaction, keeps the ring pointers and the
    // end-of-stream mark, writes appended bytes and turns reads into commands.
    pbrb_front #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .MAX_PACKET  (MAX_PACKET),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_req_type   (i_req_type),
        .i_data_byte  (i_data_byte),
        .i_end_flag   (i_end_flag),
        .i_read_limit (i_read_limit),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_back_busy  (back_busy),
        .i_cmdq_full  (cmdq_full),
        .o_cmd_push   (cmd_push),
        .o_cmd        (front_cmd),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata)
    );

    pbrb_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .o_full  (cmdq_full),
        .i_pop   (cmd_pop),
        .o_cmd   (queue_cmd),
        .o_empty (cmdq_empty)
    );

    // The back streams each command out of the store into a small result
    // queue, issuing a fetch only when the queue has room for its result.
    pbrb_back #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .MAX_PACKET  (MAX_PACKET),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmdq_empty),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (result),
        .o_busy      (back_busy)
    );

    pbrb_ram #(
        .WIDTH (pbrb_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_byte        = result.out_byte;
    assign o_byte_valid      = result.byte_valid;
    assign o_last_of_run     = result.last_of_run;
    assign o_reported_length = result.reported_length;
    assign o_read_count      = result.read_count;
    assign o_stream_done     = result.stream_done;

endmodule

/* rtl/pbrb_checker.sv */
// Port-level checks of the packetizing byte ring buffer and their binding.
module pbrb_checker #(
    parameter int MAX_PACKET = pbrb_pkg::MAX_PACKET_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         full,
    input logic                         empty,
    input logic                         pop,
    input logic [pbrb_pkg::BYTE_W-1:0]  o_out_byte,
    input logic                         o_byte_valid,
    input logic                         o_last_of_run,
    input logic [pbrb_pkg::LEN_W-1:0]   o_reported_length,
    input logic [pbrb_pkg::COUNT_W-1:0] o_read_count,
    input logic                         o_stream_done
);

    // Both queues come out of reset empty and ready.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not clear after reset");

    // A result without a byte carries a zero byte and closes its read.
    a_no_byte_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_byte_valid) |-> (o_last_of_run && (o_out_byte == '0)))
        else $error("empty-read result malformed");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_reported_length <= pbrb_pkg::LEN_W'(MAX_PACKET)))
        else $error("reported length beyond packet size");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_read_count)
                              && $stable(o_last_of_run) && $stable(o_stream_done)))
        else $error("waiting result changed");

endmodule

bind packetizing_byte_ring_buffer_unit pbrb_checker #(
    .MAX_PACKET (MAX_PACKET)
) u_pbrb_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .full              (full),
    .empty             (empty),
    .pop               (pop),
    .o_out_byte        (o_out_byte),
    .o_byte_valid      (o_byte_valid),
    .o_last_of_run     (o_last_of_run),
    .o_reported_length (o_reported_length),
    .o_read_count      (o_read_count),
    .o_stream_done     (o_stream_done)
);
